### hw/rtl/bxt_pkg.sv
// Shared types and constants for the binary trie maximum-XOR block.
// Depends on nothing; imported by bxt_cell, the top level, the checker and the testbench.
package bxt_pkg;
	localparam int KEY_BITS  = 32;
	localparam int NODE_POOL = 8192;
	localparam int NODE_W    = $clog2(NODE_POOL);
	localparam int PTR_W     = NODE_W + 1;
	localparam int LVL_W     = $clog2(KEY_BITS);
	localparam int LINKS_W   = 2 * NODE_W;
	localparam int COUNT_W   = 14;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [PTR_W-1:0] ALLOC_LIMIT = PTR_W'(NODE_POOL - KEY_BITS);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef logic [NODE_W-1:0] node_t;
	typedef node_t [1:0] links_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_STEP  = 4'b0010,
		S_FETCH = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;
endpackage

### hw/rtl/bxt_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
module bxt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/bxt_cell.sv
// One cell of the key/result chain: holds one key bit and one result bit.
// Depends on bxt_pkg.
module bxt_cell (
	input  logic               clk,
	input  bxt_pkg::cell_ctrl_t ctrl,
	input  logic               load_key,
	input  logic               key_in,
	input  logic               res_in,
	output logic               key_out,
	output logic               res_out
);
	import bxt_pkg::*;

	logic key_q;
	logic res_q;

	// load a fresh word, or advance one place toward the top
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= load_key;
			res_q <= 1'b0;
		end else if (ctrl.shift) begin
			key_q <= key_in;
			res_q <= res_in;
		end
	end

	assign key_out = key_q;
	assign res_out = res_q;
endmodule

### hw/rtl/binary_trie_max_xor.sv
// Top level of the binary trie maximum-XOR block: walker, node pool and cell chain.
// Depends on bxt_pkg, bxt_ram and bxt_cell.
//
//  channel  | dir | tdata          | tuser       | accepted when
//  s_axis   | in  | key[31:0]      | action[0]   | s_axis_tvalid & s_axis_tready
//  m_axis   | out | max_xor[31:0]  | status[1:0] | m_axis_tvalid & m_axis_tready
//
// An insert walks one level per S_STEP: a level that allocates a new node needs no pool
// read, a level that follows an existing node also passes S_FETCH for the registered pool
// read, except a followed last level, and S_DONE then posts the result. A query follows
// nodes the same way; a rejected insert or an empty-trie query goes straight to S_DONE.
// One word is in flight at a time; the next word is taken only after the result has been
// accepted, and a stalled result holds the input off.
// Reset clears the root links and key count and sets the free pointer to node 1; the pool needs no clearing.
module binary_trie_max_xor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // key[31:0]
	input  logic [0:0]  s_axis_tuser,   // action[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // max_xor[31:0]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);
	import bxt_pkg::*;

	state_t           state_q;
	logic [LVL_W-1:0] lvl_q;
	node_t            cur_q;
	links_t           links_q;
	links_t           root_q;
	logic [PTR_W-1:0] nf_q;
	logic [COUNT_W-1:0] cnt_q;
	logic             op_q;
	logic [1:0]       status_q;
	logic             mvalid_q;
	logic [1:0]       muser_q;
	logic [31:0]      mdata_q;

	// cell chain
	cell_ctrl_t          cctrl;
	logic [KEY_BITS-1:0] key_bits;
	logic [KEY_BITS-1:0] res_bits;
	logic                res_new;

	// node pool
	logic             ram_we;
	node_t            ram_waddr;
	links_t           ram_wdata;
	node_t            ram_raddr;
	logic [LINKS_W-1:0] ram_rdata;

	// step decode
	logic   kbit;
	logic   take_opp;
	node_t  nxt;
	links_t upd;
	logic   accept;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && !mvalid_q;
	assign kbit = key_bits[KEY_BITS-1];

	always_comb begin
		take_opp = 1'b0;
		nxt      = links_q[kbit];
		upd      = links_q;
		if (op_q == ACT_QUERY) begin
			take_opp = (links_q[!kbit] != '0);
			nxt      = take_opp ? links_q[!kbit] : links_q[kbit];
		end else if (nxt == '0) begin
			upd[kbit] = nf_q[NODE_W-1:0];
		end
	end

	assign res_new       = take_opp;
	assign cctrl.load    = accept;
	assign cctrl.shift   = (state_q == S_STEP);

	// write back the parent's links only when an insert allocates a child below a non-root parent
	assign ram_we    = (state_q == S_STEP) && (op_q == ACT_INSERT) && (nxt == '0)
		&& (cur_q != '0);
	assign ram_waddr = cur_q;
	assign ram_wdata = upd;
	assign ram_raddr = nxt;

	bxt_ram #(.WIDTH(LINKS_W), .DEPTH(NODE_POOL)) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
		bxt_cell u_cell (
			.clk      (clk),
			.ctrl     (cctrl),
			.load_key (s_axis_tdata[i]),
			.key_in   ((i == 0) ? 1'b0 : key_bits[(i == 0) ? 0 : i-1]),
			.res_in   ((i == 0) ? res_new : res_bits[(i == 0) ? 0 : i-1]),
			.key_out  (key_bits[i]),
			.res_out  (res_bits[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			root_q   <= '0;
			nf_q     <= PTR_W'(1);
			cnt_q    <= '0;
			mvalid_q <= 1'b0;
			op_q     <= ACT_INSERT;
			lvl_q    <= '0;
			cur_q    <= '0;
			links_q  <= '0;
			status_q <= ST_OK;
			muser_q  <= ST_OK;
			mdata_q  <= '0;
		end else begin
			if (mvalid_q && m_axis_tready) begin
				mvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= s_axis_tuser[0];
						lvl_q    <= LVL_W'(KEY_BITS - 1);
						cur_q    <= '0;
						links_q  <= root_q;
						status_q <= ST_OK;
						state_q  <= S_STEP;
						if (s_axis_tuser[0] == ACT_INSERT && nf_q > ALLOC_LIMIT) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else if (s_axis_tuser[0] == ACT_QUERY && cnt_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end
					end
				end
				S_STEP: begin
					if (op_q == ACT_INSERT && nxt == '0) begin
						// allocate: new node starts empty, no read needed
						if (cur_q == '0) begin
							root_q <= upd;
						end
						cur_q   <= nf_q[NODE_W-1:0];
						links_q <= '0;
						nf_q    <= nf_q + PTR_W'(1);
						lvl_q   <= lvl_q - LVL_W'(1);
						state_q <= (lvl_q == '0) ? S_DONE : S_STEP;
					end else if (nxt == '0) begin
						// dead path on a query: the remaining bits stay zero
						links_q <= '0;
						lvl_q   <= lvl_q - LVL_W'(1);
						state_q <= (lvl_q == '0) ? S_DONE : S_STEP;
					end else begin
						cur_q   <= nxt;
						state_q <= (lvl_q == '0) ? S_DONE : S_FETCH;
					end
				end
				S_FETCH: begin
					links_q <= ram_rdata;
					lvl_q   <= lvl_q - LVL_W'(1);
					state_q <= S_STEP;
				end
				S_DONE: begin
					if (op_q == ACT_INSERT && status_q == ST_OK && cnt_q != COUNT_MAX) begin
						cnt_q <= cnt_q + COUNT_W'(1);
					end
					mvalid_q <= 1'b1;
					muser_q  <= status_q;
					mdata_q  <= res_bits;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = mdata_q;
	assign m_axis_tuser  = muser_q;
endmodule

### hw/rtl/bxt_checker.sv
// Port-level checker for binary_trie_max_xor, attached by bind.
// Depends on bxt_pkg and the top level's ports.
module bxt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import bxt_pkg::*;

	// hold a stalled result's valid and data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// drop input readiness while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");

	// status code is always one of the three
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("bad status");

	// a failing status carries zero data
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
		else $error("nonzero data on failing status");

	// a word accepted blocks the next at once
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready after accept");
endmodule

bind binary_trie_max_xor bxt_checker u_bxt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### test/binary_trie_max_xor_tb.sv
// Testbench for binary_trie_max_xor: drives insert and query words on the slave stream
// and checks every result word against a trie predictor kept in the bench.
// Depends on bxt_pkg and the binary_trie_max_xor RTL.
module binary_trie_max_xor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bxt_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE_CYCLES = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // key[31:0]
	logic [0:0]  s_axis_tuser = '0;   // action[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // max_xor[31:0]
	logic [1:0]  m_axis_tuser;        // status[1:0]

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] max_xor;
	} trie_result_t;

	// Trie mirror: entry 0 holds the root links, a zero link means no child.
	int unsigned   zero_link [NODE_POOL];
	int unsigned   one_link  [NODE_POOL];
	int unsigned   free_node;
	int unsigned   key_count;
	logic [31:0]   stored_keys[$];
	trie_result_t  pending_results[$];

	int  error_count = 0;
	int  cycle_count = 0;
	int  burst_left  = 0;
	bit  hold_off    = 1'b0;

	always #5 clk = ~clk;

	binary_trie_max_xor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic bit pool_is_full();
		return (free_node > NODE_POOL) || (NODE_POOL - free_node < KEY_BITS);
	endfunction

	// Append one prediction at the tail of the result queue.
	function automatic void queue_prediction(trie_result_t res);
		pending_results.insert(pending_results.size(), res);
	endfunction

	// Walk from the top bit down, allocating missing nodes; reject if too few remain.
	function automatic trie_result_t trie_insert(logic [31:0] key);
		trie_result_t res;
		int unsigned cur;
		int unsigned nxt;
		res = '{status: ST_OK, max_xor: '0};
		if (pool_is_full()) begin
			res.status = ST_FULL;
			return res;
		end
		cur = 0;
		for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
			nxt = key[lvl] ? one_link[cur] : zero_link[cur];
			if (nxt == 0) begin
				nxt = free_node;
				zero_link[nxt] = 0;
				one_link[nxt]  = 0;
				if (key[lvl])
					one_link[cur] = nxt;
				else
					zero_link[cur] = nxt;
				free_node++;
			end
			cur = nxt;
		end
		if (key_count < COUNT_MAX)
			key_count++;
		stored_keys.insert(stored_keys.size(), key);
		return res;
	endfunction

	// Walk preferring the opposite bit at each level to build the greatest XOR.
	function automatic trie_result_t trie_query(logic [31:0] key);
		trie_result_t res;
		int unsigned cur;
		int unsigned opp;
		int unsigned same;
		res = '{status: ST_OK, max_xor: '0};
		if (key_count == 0) begin
			res.status = ST_EMPTY;
			return res;
		end
		cur = 0;
		for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
			opp  = key[lvl] ? zero_link[cur] : one_link[cur];
			same = key[lvl] ? one_link[cur] : zero_link[cur];
			if (opp != 0) begin
				res.max_xor[lvl] = 1'b1;
				cur = opp;
			end else if (same != 0) begin
				cur = same;
			end else begin
				break;
			end
		end
		return res;
	endfunction

	// Send one word: honor the burst/gap pattern, hold until accepted, then predict.
	task automatic send_word(logic act, logic [31:0] key);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tdata  = key;
		s_axis_tuser  = act;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (act == ACT_INSERT)
			queue_prediction(trie_insert(key));
		else
			queue_prediction(trie_query(key));
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_key();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000 | $urandom_range(0, 255);
			1: return 32'hFFFF_FFFF ^ $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	// Bias queries toward stored keys, their complements and copies with flipped bits, plus pure noise.
	function automatic logic [31:0] query_key();
		logic [31:0] base;
		if (stored_keys.size() == 0 || $urandom_range(0, 3) == 0)
			return random_key();
		base = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
		case ($urandom_range(0, 3))
			0: return base;
			1: return ~base;
			2: return base ^ (32'h1 << $urandom_range(0, 31));
			default: return base ^ ($urandom & $urandom);
		endcase
	endfunction

	task automatic test_empty_trie();
		send_word(ACT_QUERY, 32'h0000_0000);
		send_word(ACT_QUERY, 32'hFFFF_FFFF);
		send_word(ACT_QUERY, 32'hA5A5_5A5A);
	endtask

	task automatic test_directed();
		send_word(ACT_INSERT, 32'h0000_0000);
		send_word(ACT_QUERY,  32'h0000_0000);
		send_word(ACT_QUERY,  32'hFFFF_FFFF);
		send_word(ACT_INSERT, 32'hFFFF_FFFF);
		send_word(ACT_QUERY,  32'h8000_0000);
		send_word(ACT_QUERY,  32'h7FFF_FFFF);
		// duplicate key: no new nodes, count still rises
		send_word(ACT_INSERT, 32'hFFFF_FFFF);
		send_word(ACT_INSERT, 32'h5555_5555);
		send_word(ACT_INSERT, 32'hAAAA_AAAA);
		send_word(ACT_QUERY,  32'h5555_5555);
		send_word(ACT_QUERY,  32'h0000_0001);
		send_word(ACT_QUERY,  32'hFFFF_FFFE);
		send_word(ACT_INSERT, 32'h0000_0001);
		send_word(ACT_QUERY,  32'h0000_0000);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering words.
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 8; i++)
				send_word(1'($urandom_range(0, 1)), query_key());
		join
	endtask

	// Mixed traffic: about four inserts in ten, the rest queries.
	task automatic test_random_mix(int n_items);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 9) < 4)
				send_word(ACT_INSERT, $urandom_range(0, 4) == 0 ? query_key() : random_key());
			else
				send_word(ACT_QUERY, query_key());
		end
	endtask

	task automatic test_pool_full();
		while (!pool_is_full())
			send_word(ACT_INSERT, random_key());
		for (int i = 0; i < 10; i++)
			send_word(ACT_INSERT, i[0] ? 32'h0000_0000 : random_key());
		for (int i = 0; i < 20; i++)
			send_word(ACT_QUERY, query_key());
	endtask

	// Receiver stall pattern: runs of ready with random stalls, sometimes always ready.
	always @(negedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else if (cycle_count[11:9] == 3'd5)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= $urandom_range(0, 3) != 0;
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		trie_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no prediction: status %0d max_xor %h",
					m_axis_tuser, m_axis_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata !== want.max_xor) begin
					$error("max_xor: expected %h, actual %h", want.max_xor, m_axis_tdata);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		zero_link[0] = 0;
		one_link[0]  = 0;
		free_node    = 1;
		key_count    = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_trie();
		test_directed();
		test_backpressure();
		test_random_mix(500);
		test_pool_full();
		test_random_mix(680);
		s_axis_tvalid = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() == 0 && error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
